### design/iidl_pkg.sv
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared types and constants for the indexed insert/delete list.
// ----------------------------------------------------------------------------
package iidl_pkg;

  localparam int CAPACITY_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_UNDER = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [2:0]         element_index;
    logic [3:0]         entry_count;
    logic               is_empty;
    logic               last;
  } out_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [3:0]         position;
    logic signed [31:0] value;
    status_t            status;
  } op_t;

endpackage

### design/iidl_front.sv
// ----------------------------------------------------------------------------
// iidl_front
// Accepts requests, checks them against the tracked entry count and queues
// the classified operation.
// ----------------------------------------------------------------------------
module iidl_front #(
  parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  iidl_pkg::in_t request,
  input  logic          q_full,
  output logic          busy,
  output logic          q_push,
  output iidl_pkg::op_t q_op
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] count_x;
  iidl_pkg::status_t status;

  assign busy    = q_full;
  assign q_push  = start && !q_full;
  assign pos_x   = CMPW'(request.position);
  assign count_x = CMPW'(count);

  always_comb begin
    status     = iidl_pkg::ST_OK;
    count_next = count;
    if (iidl_pkg::cmd_t'(request.cmd) == iidl_pkg::CMD_INSERT) begin
      priority if (count == CW'(CAPACITY)) begin
        status = iidl_pkg::ST_FULL;
      end else if (pos_x > count_x) begin
        status = iidl_pkg::ST_RANGE;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      priority if (count == '0) begin
        status = iidl_pkg::ST_UNDER;
      end else if (pos_x >= count_x) begin
        status = iidl_pkg::ST_RANGE;
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  assign q_op = '{cmd:      iidl_pkg::cmd_t'(request.cmd),
                  position: request.position,
                  value:    request.value,
                  status:   status};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= count_next;
    end
  end

endmodule

### design/iidl_queue.sv
// ----------------------------------------------------------------------------
// iidl_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module iidl_queue #(
  parameter int DEPTH = iidl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  iidl_pkg::op_t push_op,
  input  logic          pop,
  output iidl_pkg::op_t pop_op,
  output logic          full,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);

  iidl_pkg::op_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   used;
  logic          do_push;
  logic          do_pop;

  assign full    = (used == (AW+1)'(DEPTH));
  assign empty   = (used == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   used <= used + (AW+1)'(1);
        2'b01:   used <= used - (AW+1)'(1);
        default: used <= used;
      endcase
    end
  end

endmodule

### design/iidl_back.sv
// ----------------------------------------------------------------------------
// iidl_back
// Applies queued operations to the list with a parallel shift and streams the
// contents out, one element per cycle; an error or an emptied list gives a single result.
// ----------------------------------------------------------------------------
module iidl_back #(
  parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  iidl_pkg::op_t  q_op,
  output logic           q_pop,
  output iidl_pkg::out_t result,
  output logic           result_valid
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t             state;
  logic signed [31:0] entries  [CAPACITY];
  logic signed [31:0] snap     [CAPACITY];
  logic signed [31:0] shifted  [CAPACITY];
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  logic [CW-1:0]      k;
  logic               emit_last;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign emit_last = (k == cnt - CW'(1));

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (q_op.cmd == iidl_pkg::CMD_INSERT) begin
        if (i < int'(q_op.position)) begin
          shifted[i] = entries[i];
        end else if (i == int'(q_op.position)) begin
          shifted[i] = q_op.value;
        end else begin
          shifted[i] = entries[(i > 0) ? i - 1 : 0];
        end
      end else begin
        if (i < int'(q_op.position) || i == CAPACITY - 1) begin
          shifted[i] = entries[i];
        end else begin
          shifted[i] = entries[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
    cnt_next = (q_op.cmd == iidl_pkg::CMD_INSERT) ? cnt + CW'(1) : cnt - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op.status == iidl_pkg::ST_OK) begin
      entries <= shifted;
      snap    <= shifted;
    end else if (state == S_EMIT) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        snap[i] <= snap[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      k            <= '0;
      result_valid <= 1'b0;
      result       <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_op.status != iidl_pkg::ST_OK) begin
              result_valid <= 1'b1;
              result       <= '{status: q_op.status, element: '0, element_index: '0,
                                entry_count: 4'(cnt), is_empty: 1'b0, last: 1'b1};
            end else begin
              cnt <= cnt_next;
              k   <= '0;
              if (cnt_next == '0) begin
                result_valid <= 1'b1;
                result       <= '{status: iidl_pkg::ST_OK, element: '0, element_index: '0,
                                  entry_count: '0, is_empty: 1'b1, last: 1'b1};
              end else begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          result       <= '{status: iidl_pkg::ST_OK, element: snap[0],
                            element_index: 3'(k), entry_count: 4'(cnt),
                            is_empty: 1'b0, last: emit_last};
          k            <= k + CW'(1);
          if (emit_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/indexed_insert_delete_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Packed list of signed words with insert/delete at an index; every request
// is answered by the full list contents or by a single error result.
//
//   channel   signals                        handshake
//   request   start, request, busy           taken when start && !busy
//   result    result_valid, result           one-cycle strobe, no backpressure
//
// A successful request first applies the parallel shift and then emits the
// elements in order; errors and an emptied list give a single result. Reset
// clears the count; the list storage holds no reset value. busy rises only
// when the request queue is full.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list #(
  parameter int CAPACITY    = iidl_pkg::CAPACITY_DEF,
  parameter int QUEUE_DEPTH = iidl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  iidl_pkg::in_t  request,
  output logic           busy,
  output iidl_pkg::out_t result,
  output logic           result_valid
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  iidl_pkg::op_t push_op;
  iidl_pkg::op_t pop_op;

  iidl_front #(.CAPACITY(CAPACITY)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_op    (push_op)
  );

  iidl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  iidl_back #(.CAPACITY(CAPACITY)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_op         (pop_op),
    .q_pop        (q_pop),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

### test/indexed_insert_delete_list_tb.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_tb
// Self-checking bench for the indexed insert/delete list. A directed table
// covers the empty, full and out-of-range cases, the extreme words and
// inserts and deletes at the front, middle and back. Random requests follow,
// mostly well-formed with some noise, and the sender gap rate changes across
// three phases. A shadow copy of the list predicts each result strobe unless a
// table row gives its own; each strobe is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_tb;
  import iidl_pkg::*;

  localparam int CAPACITY         = CAPACITY_DEF;
  localparam int RANDOM_PER_PHASE = 167;
  localparam int DIRECTED_ROWS    = 24;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 200000;

  typedef struct packed {
    in_t  req;
    bit   typed;
    out_t res;
  } directed_row_t;

  typedef struct packed {
    bit   typed;
    out_t res;
  } typed_note_t;

  logic clk;
  logic rst;
  logic start;
  in_t  request;
  logic busy;
  out_t result;
  logic result_valid;

  logic signed [31:0] shadow_list [CAPACITY];
  logic [3:0]         shadow_count;
  out_t               step_results [CAPACITY];
  int                 step_len;

  out_t          expected_results [$];
  typed_note_t   typed_notes [$];
  directed_row_t directed_rows [DIRECTED_ROWS];

  out_t        want;
  typed_note_t note;
  int          fail_count;
  int          accepted_count;
  int          result_count;
  int          error_count;
  int          gen_count;

  indexed_insert_delete_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result(result),
    .result_valid(result_valid)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic step_shadow_list(input in_t r);
    status_t st;
    int      p;
    st = ST_OK;
    p  = int'(r.position);
    if (r.cmd == CMD_INSERT) begin
      if (shadow_count >= 4'(CAPACITY)) begin
        st = ST_FULL;
      end else if (r.position > shadow_count) begin
        st = ST_RANGE;
      end else begin
        for (int i = int'(shadow_count); i > p; i--) shadow_list[i] = shadow_list[i - 1];
        shadow_list[p] = r.value;
        shadow_count   = shadow_count + 4'd1;
      end
    end else begin
      if (shadow_count == '0) begin
        st = ST_UNDER;
      end else if (r.position >= shadow_count) begin
        st = ST_RANGE;
      end else begin
        for (int i = p; i + 1 < int'(shadow_count); i++) shadow_list[i] = shadow_list[i + 1];
        shadow_count = shadow_count - 4'd1;
      end
    end
    if (st != ST_OK) begin
      step_results[0] = '{status: st, element: '0, element_index: '0,
                          entry_count: shadow_count, is_empty: 1'b0, last: 1'b1};
      step_len = 1;
    end else if (shadow_count == '0) begin
      step_results[0] = '{status: ST_OK, element: '0, element_index: '0,
                          entry_count: '0, is_empty: 1'b1, last: 1'b1};
      step_len = 1;
    end else begin
      for (int k = 0; k < int'(shadow_count); k++) begin
        step_results[k] = '{status: ST_OK, element: shadow_list[k], element_index: 3'(k),
                            entry_count: shadow_count, is_empty: 1'b0,
                            last: (k + 1 == int'(shadow_count))};
      end
      step_len = int'(shadow_count);
    end
  endtask

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: %p", result);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", longint'(want.status), longint'(result.status));
          check_field("element", longint'(want.element), longint'(result.element));
          check_field("element_index", longint'(want.element_index),
                      longint'(result.element_index));
          check_field("entry_count", longint'(want.entry_count),
                      longint'(result.entry_count));
          check_field("is_empty", longint'(want.is_empty), longint'(result.is_empty));
          check_field("last", longint'(want.last), longint'(result.last));
        end
      end
      if (start && !busy) begin
        note = '0;
        if (typed_notes.size() != 0) note = typed_notes.pop_front();
        step_shadow_list(request);
        accepted_count++;
        if (step_results[0].status != ST_OK) error_count++;
        if (note.typed) begin
          expected_results.push_back(note.res);
        end else begin
          for (int k = 0; k < step_len; k++) expected_results.push_back(step_results[k]);
        end
      end
    end
  end

  function automatic directed_row_t mk_row(cmd_t c, int pos, logic [31:0] v, bit typed,
                                           status_t st, int cnt, bit empty);
    directed_row_t r_out;
    r_out.req   = '{cmd: c, position: 4'(pos), value: v};
    r_out.typed = typed;
    r_out.res   = '{status: st, element: '0, element_index: '0,
                    entry_count: 4'(cnt), is_empty: empty, last: 1'b1};
    return r_out;
  endfunction

  function automatic int next_count(in_t r, int c);
    if (r.cmd == CMD_INSERT) begin
      if (c < CAPACITY && int'(r.position) <= c) return c + 1;
    end else begin
      if (c > 0 && int'(r.position) < c) return c - 1;
    end
    return c;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input in_t r, input bit typed, input out_t res);
    typed_notes.push_back('{typed: typed, res: res});
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start   <= 1'b0;
      request <= in_t'({1'($urandom), 4'($urandom), $urandom});
      @(posedge clk);
    end
  endtask

  initial begin
    in_t     r;
    int      pct;
    bit      noise;
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    shadow_count   = '0;
    fail_count     = 0;
    accepted_count = 0;
    result_count   = 0;
    error_count    = 0;
    gen_count      = 0;

    directed_rows = '{
      mk_row(CMD_DELETE, 0,  32'h0000_0000, 1, ST_UNDER, 0, 0),
      mk_row(CMD_DELETE, 15, 32'hFFFF_FFFF, 1, ST_UNDER, 0, 0),
      mk_row(CMD_INSERT, 1,  32'h0000_0005, 1, ST_RANGE, 0, 0),
      mk_row(CMD_INSERT, 15, 32'h0000_0007, 1, ST_RANGE, 0, 0),
      mk_row(CMD_INSERT, 0,  32'h7FFF_FFFF, 0, ST_OK, 0, 0),
      mk_row(CMD_DELETE, 0,  32'h0000_0000, 1, ST_OK, 0, 1),
      mk_row(CMD_INSERT, 0,  32'h8000_0000, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 1,  32'h7FFF_FFFF, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 0,  32'hFFFF_FFFF, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 1,  32'h0000_0000, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 4,  32'h5555_5555, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 5,  32'hAAAA_AAAA, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 0,  32'h0000_0001, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 3,  32'h1234_5678, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 8,  32'h0000_0009, 1, ST_FULL, 8, 0),
      mk_row(CMD_INSERT, 0,  32'h0000_0009, 1, ST_FULL, 8, 0),
      mk_row(CMD_DELETE, 8,  32'h0000_0000, 1, ST_RANGE, 8, 0),
      mk_row(CMD_DELETE, 15, 32'h0000_0000, 1, ST_RANGE, 8, 0),
      mk_row(CMD_DELETE, 7,  32'h0000_0000, 0, ST_OK, 0, 0),
      mk_row(CMD_DELETE, 0,  32'h0000_0000, 0, ST_OK, 0, 0),
      mk_row(CMD_DELETE, 3,  32'h0000_0000, 0, ST_OK, 0, 0),
      mk_row(CMD_INSERT, 6,  32'h0000_0003, 1, ST_RANGE, 5, 0),
      mk_row(CMD_DELETE, 5,  32'h0000_0000, 1, ST_RANGE, 5, 0),
      mk_row(CMD_INSERT, 5,  32'h0F0F_0F0F, 0, ST_OK, 0, 0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      idle_gap(13);
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
      gen_count = next_count(directed_rows[i].req, gen_count);
    end

    for (int ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 13 : (ph == 1) ? 78 : 0;
      repeat (RANDOM_PER_PHASE) begin
        idle_gap(pct);
        noise   = ($urandom_range(99) < 15);
        r.value = pick_value();
        if (noise) begin
          r.cmd      = 1'($urandom);
          r.position = 4'($urandom_range(15));
        end else begin
          if (gen_count == 0) r.cmd = CMD_INSERT;
          else if (gen_count == CAPACITY) r.cmd = CMD_DELETE;
          else r.cmd = 1'($urandom);
          if (r.cmd == CMD_INSERT) r.position = 4'($urandom_range(gen_count));
          else r.position = 4'($urandom_range(gen_count - 1));
        end
        send_request(r, 1'b0, '0);
        gen_count = next_count(r, gen_count);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d from the directed table), %0d results seen",
             accepted_count, DIRECTED_ROWS, result_count);
    $display("%0d requests were refused with an error status", error_count);
    if (fail_count == 0) begin
      $display("indexed_insert_delete_list_tb OK");
    end else begin
      $display("indexed_insert_delete_list_tb NOT OK");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, expected_results.size());
    $display("indexed_insert_delete_list_tb NOT OK");
    $finish;
  end

endmodule

### indexed_insert_delete_list.f
design/iidl_pkg.sv
design/iidl_front.sv
design/iidl_queue.sv
design/iidl_back.sv
design/indexed_insert_delete_list.sv
test/indexed_insert_delete_list_tb.sv
